>>> rtl/core/alrv_pkg.sv
`default_nettype none

package alrv_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_READ,
    ST_PURGE,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

>>> rtl/core/array_list_remove_value.sv
`default_nettype none

// Array list of up to 64 signed 32-bit entries held in a single-port-read,
// single-port-write synchronous RAM, plus a length counter. A transaction is
// an append (0), a remove-all-equal (1) or a read at index (2); each one
// yields exactly one result on the output channel. An append passes through
// the append state and a read through the read state before the finish
// state; an unknown code or a remove on an empty list goes straight to the
// finish state. A remove streams the list through the RAM read port with a
// trailing write pointer in the purge state, compacting in place. One
// request is in flight at a time; the output register lets the block accept
// the next request while a result still waits to be taken, but a request
// that finishes while that result is still held stays in its last cycle
// until the output register frees up.
module array_list_remove_value import alrv_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [5:0]        index_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   ok_o,
  output logic                   found_o,
  output logic [6:0]             list_length_o,
  output logic signed [31:0]     read_value_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic              res_ok_q, res_ok_d;
  logic              res_found_q, res_found_d;
  logic [DATA_W-1:0] res_rdata_q, res_rdata_d;

  logic              out_valid_q, out_valid_d;
  logic              out_ok_q, out_ok_d;
  logic              out_found_q, out_found_d;
  logic [CNT_W-1:0]  out_len_q, out_len_d;
  logic [DATA_W-1:0] out_rdata_q, out_rdata_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              keep;
  logic [CNT_W-1:0]  wr_next;

  alrv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign keep       = (ram_rdata != val_q);
  assign wr_next    = wr_ptr_q + CNT_W'(keep);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    val_d       = val_q;
    res_ok_d    = res_ok_q;
    res_found_d = res_found_q;
    res_rdata_d = res_rdata_q;
    out_valid_d = out_valid_q;
    out_ok_d    = out_ok_q;
    out_found_d = out_found_q;
    out_len_d   = out_len_q;
    out_rdata_d = out_rdata_q;
    ram_we      = 1'b0;
    ram_waddr   = wr_ptr_q[ADDR_W-1:0];
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = rd_ptr_q[ADDR_W-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d       = value_i;
          res_ok_d    = 1'b0;
          res_found_d = 1'b0;
          res_rdata_d = '0;
          case (req_e'(req_type_i))
            REQ_APPEND: begin
              state_d = ST_APPEND;
            end
            REQ_REMOVE: begin
              res_ok_d = 1'b1;
              if (count_q == '0) begin
                state_d = ST_FINISH;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                rd_ptr_d  = CNT_W'(1);
                wr_ptr_d  = '0;
                state_d   = ST_PURGE;
              end
            end
            REQ_READ: begin
              res_ok_d  = ({1'b0, index_i} < count_q);
              ram_re    = 1'b1;
              ram_raddr = index_i;
              state_d   = ST_READ;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_APPEND: begin
        if (count_q < CNT_W'(DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = count_q[ADDR_W-1:0];
          ram_wdata = val_q;
          count_d   = count_q + CNT_W'(1);
          res_ok_d  = 1'b1;
        end
        state_d = ST_FINISH;
      end

      ST_READ: begin
        res_rdata_d = res_ok_q ? ram_rdata : '0;
        state_d     = ST_FINISH;
      end

      ST_PURGE: begin
        // ram_rdata holds entry rd_ptr_q-1; write side trails the read side
        ram_we   = keep;
        wr_ptr_d = wr_next;
        if (rd_ptr_q == count_q) begin
          count_d     = wr_next;
          res_found_d = (wr_next != count_q);
          state_d     = ST_FINISH;
        end else begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + CNT_W'(1);
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_found_d = res_found_q;
          out_len_d   = count_q;
          out_rdata_d = res_rdata_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q    <= rd_ptr_d;
    wr_ptr_q    <= wr_ptr_d;
    val_q       <= val_d;
    res_ok_q    <= res_ok_d;
    res_found_q <= res_found_d;
    res_rdata_q <= res_rdata_d;
    out_ok_q    <= out_ok_d;
    out_found_q <= out_found_d;
    out_len_q   <= out_len_d;
    out_rdata_q <= out_rdata_d;
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign found_o       = out_found_q;
  assign list_length_o = out_len_q;
  assign read_value_o  = out_rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/alrv_ram.sv
`default_nettype none

module alrv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/alrv_checker.sv
`default_nettype none

module alrv_checker import alrv_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               ok_o,
  input wire logic               found_o,
  input wire logic [6:0]         list_length_o,
  input wire logic signed [31:0] read_value_o
);

  // one request in flight: ready drops right after an accepted transaction
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(list_length_o)
      && $stable(read_value_o) && $stable(ok_o) && $stable(found_o))
    else $error("result dropped or changed while stalled");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> list_length_o <= 7'(DEPTH))
    else $error("list length beyond capacity");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> ok_o)
    else $error("found without ok");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> read_value_o == '0 && !found_o)
    else $error("refused transaction carries data");

endmodule

bind array_list_remove_value alrv_checker u_alrv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .ok_o          (ok_o),
  .found_o       (found_o),
  .list_length_o (list_length_o),
  .read_value_o  (read_value_o)
);

`default_nettype wire
